### sv/stcf_pkg.sv
// Package: shared types and constants for the thread scheduler.
package stcf_pkg;

    localparam int MAX_THREADS_DEF  = 16;
    localparam int QUANTA_WIDTH_DEF = 32;
    localparam int ID_W             = 16;
    localparam int STATUS_W         = 3;
    localparam int FUNC_W           = 2;
    localparam int OUT_Q_W          = 32;

    localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EXIT   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_JOIN   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd4;

    typedef enum logic [1:0] {
        MODE_FREE    = 2'd0,
        MODE_READY   = 2'd1,
        MODE_RUNNING = 2'd2,
        MODE_TERM    = 2'd3
    } mode_t;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_BUMP   = 8'b0000_0100,
        S_PICK   = 8'b0000_1000,
        S_SHIFT  = 8'b0001_0000,
        S_JOIN   = 8'b0010_0000,
        S_FINISH = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    // Compare request and answer between sequencer and shared comparator.
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
    } cmp_req_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_rsp_t;

endpackage

### sv/stcf_cmp.sv
// Shared unsigned compare unit used by the pick and join scans of the sequencer.
module stcf_cmp
    import stcf_pkg::*;
(
    input  cmp_req_t req,
    output cmp_rsp_t rsp
);
    assign rsp.lt = req.a < req.b;
    assign rsp.eq = req.a == req.b;
endmodule

### sv/thread_stcf_scheduler.sv
// Top level: thread table, run queue and scan sequencer of the STCF scheduler.
// One transaction in flight: the sequencer walks the slot table (create, join)
//   or the run queue (tick, exit), the join and queue walks going through the
//   single compare unit; s_tready is high only in idle with the result register
//   empty.
// Reset: async active low; slot 0 holds running thread id 1, queue length one,
//   next id two, finished clear; the result register is empty.
module thread_stcf_scheduler
    import stcf_pkg::*;
#(
    parameter int MAX_THREADS  = MAX_THREADS_DEF,
    parameter int QUANTA_WIDTH = QUANTA_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // func[1:0], target_id[17:2], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata   // status[2:0], running_id[18:3], new_id[34:19],
                                  // running_quanta[66:35], zero fill
);
    localparam int SW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int LW = $clog2(MAX_THREADS + 1);
    localparam logic [QUANTA_WIDTH-1:0] QMAX = '1;

    // Thread table and queue; small, each entry at its own register.
    logic [ID_W-1:0]         tid_reg   [MAX_THREADS];
    logic [QUANTA_WIDTH-1:0] quanta_reg[MAX_THREADS];
    mode_t                   mode_reg  [MAX_THREADS];
    logic [SW-1:0]           order_reg [MAX_THREADS];
    logic [LW-1:0]           qlen_reg;
    logic [ID_W-1:0]         next_id_reg;
    logic                    finished_reg;

    state_t             state_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [ID_W-1:0]    target_reg;
    logic [LW-1:0]      idx_reg;       // scan index
    logic [SW-1:0]      best_reg;      // best queue position / found slot
    logic               found_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]    new_id_reg;
    logic               out_valid_reg;
    logic [71:0]        out_data_reg;

    logic [SW-1:0] idx_s;
    assign idx_s = idx_reg[SW-1:0];

    // Shared comparator: quanta at queue[idx] vs quanta at queue[best],
    // or slot id vs target during join scan.
    cmp_req_t req;
    cmp_rsp_t rsp;
    always_comb
    begin
        req = '0;
        if (state_reg == S_JOIN)
        begin
            req.a = 64'(tid_reg[idx_s]);
            req.b = 64'(target_reg);
        end
        else
        begin
            req.a = 64'(quanta_reg[order_reg[idx_s]]);
            req.b = 64'(quanta_reg[order_reg[best_reg]]);
        end
    end

    stcf_cmp u_cmp (.req(req), .rsp(rsp));

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    logic [SW-1:0] front;
    assign front = order_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                tid_reg[i]    <= '0;
                quanta_reg[i] <= '0;
                mode_reg[i]   <= MODE_FREE;
                order_reg[i]  <= '0;
            end
            tid_reg[0]    <= ID_W'(1);
            mode_reg[0]   <= MODE_RUNNING;
            qlen_reg      <= LW'(1);
            next_id_reg   <= ID_W'(2);
            finished_reg  <= 1'b0;
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            func_reg      <= '0;
            target_reg    <= '0;
            idx_reg       <= '0;
            best_reg      <= '0;
            found_reg     <= 1'b0;
            status_reg    <= ST_OK;
            new_id_reg    <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            // result register is always empty while in S_OUT
            if (out_valid_reg && m_tready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        func_reg   <= s_tdata[1:0];
                        target_reg <= s_tdata[17:2];
                        idx_reg    <= '0;
                        found_reg  <= 1'b0;
                        best_reg   <= '0;
                        new_id_reg <= '0;
                        if (finished_reg)
                        begin
                            status_reg <= ST_DONE;
                            state_reg  <= S_OUT;
                        end
                        else if (s_tdata[1:0] == FUNC_CREATE)
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_SCAN;
                        end
                        else if (s_tdata[1:0] == FUNC_JOIN)
                        begin
                            status_reg <= ST_NOTFOUND;
                            state_reg  <= S_JOIN;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_BUMP;
                        end
                    end
                end
                S_SCAN:
                begin
                    // Look for the first free slot.
                    if (!found_reg && mode_reg[idx_s] == MODE_FREE)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= idx_s;
                    end
                    if (idx_reg == LW'(MAX_THREADS - 1))
                    begin
                        state_reg <= S_OUT;
                        if (!(found_reg || mode_reg[idx_s] == MODE_FREE) ||
                            next_id_reg == '0 || qlen_reg >= LW'(MAX_THREADS))
                            status_reg <= ST_FULL;
                        else
                        begin
                            logic [SW-1:0] fs;
                            fs = found_reg ? best_reg : idx_s;
                            tid_reg[fs]    <= next_id_reg;
                            quanta_reg[fs] <= '0;
                            mode_reg[fs]   <= MODE_READY;
                            order_reg[qlen_reg[SW-1:0]] <= fs;
                            qlen_reg       <= qlen_reg + LW'(1);
                            new_id_reg     <= next_id_reg;
                            next_id_reg    <= next_id_reg + ID_W'(1);
                        end
                    end
                    else
                        idx_reg <= idx_reg + LW'(1);
                end
                S_BUMP:
                begin
                    if (qlen_reg == '0)
                    begin
                        finished_reg <= 1'b1;
                        status_reg   <= ST_DONE;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        if (quanta_reg[front] != QMAX)
                            quanta_reg[front] <= quanta_reg[front] + 1'b1;
                        if (func_reg == FUNC_EXIT)
                        begin
                            mode_reg[front] <= MODE_TERM;
                            for (int i = 0; i < MAX_THREADS - 1; i++)
                                order_reg[i] <= order_reg[i+1];
                            qlen_reg <= qlen_reg - LW'(1);
                            if (qlen_reg == LW'(1))
                            begin
                                finished_reg <= 1'b1;
                                status_reg   <= ST_DONE;
                                state_reg    <= S_OUT;
                            end
                            else
                            begin
                                idx_reg   <= LW'(1);
                                best_reg  <= '0;
                                state_reg <= S_PICK;
                            end
                        end
                        else
                        begin
                            mode_reg[front] <= MODE_READY;
                            idx_reg   <= LW'(1);
                            best_reg  <= '0;
                            state_reg <= S_PICK;
                        end
                    end
                end
                S_PICK:
                begin
                    // One queue entry per cycle through the shared comparator.
                    if (idx_reg >= qlen_reg)
                    begin
                        idx_reg   <= LW'(best_reg);
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        if (rsp.lt)
                            best_reg <= idx_s;
                        idx_reg <= idx_reg + LW'(1);
                    end
                end
                S_SHIFT:
                begin
                    // Rotate best entry to the front in one pass.
                    for (int i = 1; i < MAX_THREADS; i++)
                        if (SW'(i) <= best_reg)
                            order_reg[i] <= order_reg[i-1];
                    order_reg[0] <= order_reg[best_reg];
                    mode_reg[order_reg[best_reg]] <= MODE_RUNNING;
                    state_reg <= S_OUT;
                end
                S_JOIN:
                begin
                    if (!found_reg && mode_reg[idx_s] != MODE_FREE && rsp.eq)
                    begin
                        found_reg <= 1'b1;
                        if (mode_reg[idx_s] == MODE_TERM)
                        begin
                            mode_reg[idx_s]   <= MODE_FREE;
                            tid_reg[idx_s]    <= '0;
                            quanta_reg[idx_s] <= '0;
                            status_reg        <= ST_OK;
                        end
                        else
                            status_reg <= ST_WAIT;
                    end
                    if (idx_reg == LW'(MAX_THREADS - 1))
                        state_reg <= S_OUT;
                    else
                        idx_reg <= idx_reg + LW'(1);
                end
                S_FINISH:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    logic [OUT_Q_W-1:0] q32;
                    logic [ID_W-1:0]    rid;
                    q32 = '0;
                    rid = '0;
                    if (!finished_reg && qlen_reg != '0)
                    begin
                        rid = tid_reg[front];
                        if (QUANTA_WIDTH > OUT_Q_W &&
                            (64'(quanta_reg[front]) >> OUT_Q_W) != 64'd0)
                            q32 = '1;
                        else
                            q32 = OUT_Q_W'(64'(quanta_reg[front]));
                    end
                    out_data_reg  <= {5'd0, q32, new_id_reg, rid, status_reg};
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_qlen: assert property (@(posedge clk) disable iff (!rst_n)
        qlen_reg <= LW'(MAX_THREADS)) else $error("queue overflow");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("accepted while busy");
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $past(finished_reg) |-> finished_reg) else $error("finished cleared");
endmodule
